// ----- src/fdm_pkg.sv -----
`timescale 1ns / 1ps

package fdm_pkg;

   // register indexes on the csr port (byte address is 8 * index)
   localparam logic [1:0] REG_QUERY_NAME = 2'd0;
   localparam logic [1:0] REG_QUERY_EXT  = 2'd1;
   localparam logic [1:0] REG_NAME_LEN   = 2'd2;
   localparam logic [1:0] REG_EXT_LEN    = 2'd3;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   // byte offsets inside a 32-byte directory entry
   localparam logic [4:0] POS_EXT_FIRST = 5'd8;
   localparam logic [4:0] POS_ATTR      = 5'hB;
   localparam logic [4:0] POS_HIGH_LO   = 5'd20;
   localparam logic [4:0] POS_HIGH_HI   = 5'd21;
   localparam logic [4:0] POS_LOW_LO    = 5'd26;
   localparam logic [4:0] POS_LOW_HI    = 5'd27;
   localparam logic [4:0] POS_LAST      = 5'd31;

   localparam logic [7:0] ATTR_END  = 8'h00;
   localparam logic [7:0] ATTR_LONG = 8'hF;

   localparam int CLUSTER_HIGH_SHIFT = 'h10;

   typedef struct packed {
      logic [63:0] query_name;
      logic [23:0] query_ext;
      logic [3:0]  name_len;
      logic [1:0]  ext_len;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] dir_byte;
   } stage_type;

endpackage

// ----- src/fdm_csr.sv -----
`timescale 1ns / 1ps

module fdm_csr
   import fdm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:3];
   assign wr_en     = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_QUERY_NAME: cfg_in.query_name = pwdata;
            REG_QUERY_EXT:  cfg_in.query_ext  = pwdata[23:0];
            REG_NAME_LEN:   cfg_in.name_len   = pwdata[3:0];
            REG_EXT_LEN:    cfg_in.ext_len    = pwdata[1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_QUERY_NAME: prdata = cfg_ff.query_name;
         REG_QUERY_EXT:  prdata = {40'd0, cfg_ff.query_ext};
         REG_NAME_LEN:   prdata = {60'd0, cfg_ff.name_len};
         REG_EXT_LEN:    prdata = {62'd0, cfg_ff.ext_len};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.query_name <= '0;
         cfg_ff.query_ext  <= '0;
         cfg_ff.name_len   <= 4'd8;
         cfg_ff.ext_len    <= 2'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/fdm_in_stage.sv -----
`timescale 1ns / 1ps

module fdm_in_stage
   import fdm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_dir_byte,
   input  logic       advance,
   output stage_type  stage
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   // hold the byte only while the scan cannot take it
   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_dir_byte;
      end
   end

   assign stage.valid    = valid_ff;
   assign stage.dir_byte = byte_ff;

endmodule

// ----- src/fdm_scan.sv -----
`timescale 1ns / 1ps

module fdm_scan
   import fdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  stage_type   stage,
   output logic        advance,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [31:0] rsp_start_cluster,
   output logic [63:0] rsp_match_name,
   output logic [23:0] rsp_match_ext
);

   logic [4:0]  pos_ff, pos_in;
   logic        prev_long_ff, prev_long_in;
   logic        cur_long_ff, cur_long_in;
   logic        name_eq_ff, name_eq_in;
   logic        name_stop_ff, name_stop_in;
   logic        ext_eq_ff, ext_eq_in;
   logic        ext_stop_ff, ext_stop_in;
   logic [63:0] ent_name_ff, ent_name_in;
   logic [23:0] ent_ext_ff, ent_ext_in;
   logic [31:0] cluster_ff, cluster_in;
   logic        hit_ff, hit_in;
   logic [31:0] hit_cluster_ff, hit_cluster_in;
   logic [63:0] hit_name_ff, hit_name_in;
   logic [23:0] hit_ext_ff, hit_ext_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_found_ff;
   logic [31:0] out_cluster_ff;
   logic [63:0] out_name_ff;
   logic [23:0] out_ext_ff;

   logic [7:0]  b;
   logic        is_end;
   logic        emit;
   logic [7:0]  q_name_byte;
   logic [7:0]  q_ext_byte;
   logic [1:0]  ext_k;

   assign b      = stage.dir_byte;
   assign is_end = (pos_ff == POS_ATTR) && (b == ATTR_END);
   // an end marker waits while the previous result is still held
   assign advance = stage.valid & ~(is_end & out_valid_ff & rsp_stall);
   assign emit    = advance & is_end;

   assign ext_k       = pos_ff[1:0];
   assign q_name_byte = cfg.query_name[{pos_ff[2:0], 3'b000} +: 8];

   always_comb begin
      case (ext_k)
         2'd0:    q_ext_byte = cfg.query_ext[7:0];
         2'd1:    q_ext_byte = cfg.query_ext[15:8];
         2'd2:    q_ext_byte = cfg.query_ext[23:16];
         default: q_ext_byte = 8'd0;
      endcase
   end

   always_comb begin
      pos_in         = pos_ff;
      prev_long_in   = prev_long_ff;
      cur_long_in    = cur_long_ff;
      name_eq_in     = name_eq_ff;
      name_stop_in   = name_stop_ff;
      ext_eq_in      = ext_eq_ff;
      ext_stop_in    = ext_stop_ff;
      ent_name_in    = ent_name_ff;
      ent_ext_in     = ent_ext_ff;
      cluster_in     = cluster_ff;
      hit_in         = hit_ff;
      hit_cluster_in = hit_cluster_ff;
      hit_name_in    = hit_name_ff;
      hit_ext_in     = hit_ext_ff;

      if (advance) begin
         pos_in = pos_ff + 5'd1;
         if (pos_ff < POS_EXT_FIRST) begin
            ent_name_in[{pos_ff[2:0], 3'b000} +: 8] = b;
            // name_len of eight or more covers every name byte
            if (({1'b0, pos_ff[2:0]} < cfg.name_len) && !name_stop_ff) begin
               if (b != q_name_byte) begin
                  name_eq_in   = 1'b0;
                  name_stop_in = 1'b1;
               end else if (b == 8'd0) begin
                  name_stop_in = 1'b1;
               end
            end
         end else if (pos_ff < POS_ATTR) begin
            case (ext_k)
               2'd0:    ent_ext_in[7:0]   = b;
               2'd1:    ent_ext_in[15:8]  = b;
               default: ent_ext_in[23:16] = b;
            endcase
            if ((ext_k < cfg.ext_len) && !ext_stop_ff) begin
               if (b != q_ext_byte) begin
                  ext_eq_in   = 1'b0;
                  ext_stop_in = 1'b1;
               end else if (b == 8'd0) begin
                  ext_stop_in = 1'b1;
               end
            end
         end else if (pos_ff == POS_ATTR) begin
            cur_long_in = (b == ATTR_LONG);
         end else if (pos_ff == POS_HIGH_LO) begin
            cluster_in[CLUSTER_HIGH_SHIFT +: 8] = b;
         end else if (pos_ff == POS_HIGH_HI) begin
            cluster_in[CLUSTER_HIGH_SHIFT + 8 +: 8] = b;
         end else if (pos_ff == POS_LOW_LO) begin
            cluster_in[7:0] = b;
         end else if (pos_ff == POS_LOW_HI) begin
            cluster_in[15:8] = b;
         end

         if (pos_ff == POS_LAST) begin
            if (!cur_long_ff && !prev_long_ff && name_eq_ff && ext_eq_ff) begin
               hit_in         = 1'b1;
               hit_cluster_in = cluster_ff;
               hit_name_in    = ent_name_ff;
               hit_ext_in     = ent_ext_ff;
            end
            prev_long_in = cur_long_ff;
            pos_in       = 5'd0;
            cur_long_in  = 1'b0;
            name_eq_in   = 1'b1;
            name_stop_in = 1'b0;
            ext_eq_in    = 1'b1;
            ext_stop_in  = 1'b0;
         end

         // end of directory: restart the whole search
         if (is_end) begin
            pos_in         = 5'd0;
            cur_long_in    = 1'b0;
            name_eq_in     = 1'b1;
            name_stop_in   = 1'b0;
            ext_eq_in      = 1'b1;
            ext_stop_in    = 1'b0;
            prev_long_in   = 1'b0;
            hit_in         = 1'b0;
            hit_cluster_in = '0;
            hit_name_in    = '0;
            hit_ext_in     = '0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         prev_long_ff   <= 1'b0;
         cur_long_ff    <= 1'b0;
         name_eq_ff     <= 1'b1;
         name_stop_ff   <= 1'b0;
         ext_eq_ff      <= 1'b1;
         ext_stop_ff    <= 1'b0;
         hit_ff         <= 1'b0;
         hit_cluster_ff <= '0;
         hit_name_ff    <= '0;
         hit_ext_ff     <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         prev_long_ff   <= prev_long_in;
         cur_long_ff    <= cur_long_in;
         name_eq_ff     <= name_eq_in;
         name_stop_ff   <= name_stop_in;
         ext_eq_ff      <= ext_eq_in;
         ext_stop_ff    <= ext_stop_in;
         hit_ff         <= hit_in;
         hit_cluster_ff <= hit_cluster_in;
         hit_name_ff    <= hit_name_in;
         hit_ext_ff     <= hit_ext_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // entry bytes are all rewritten before an entry is judged
   always_ff @(posedge clock) begin
      ent_name_ff <= ent_name_in;
      ent_ext_ff  <= ent_ext_in;
      cluster_ff  <= cluster_in;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_found_ff   <= hit_ff;
         out_cluster_ff <= hit_cluster_ff;
         out_name_ff    <= hit_name_ff;
         out_ext_ff     <= hit_ext_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_found         = out_found_ff;
   assign rsp_start_cluster = out_cluster_ff;
   assign rsp_match_name    = out_name_ff;
   assign rsp_match_ext     = out_ext_ff;

endmodule

// ----- src/fat_dir_entry_name_match.sv -----
`timescale 1ns / 1ps

// Short-name lookup over a FAT32 directory streamed one byte per item, 32 bytes per
// entry. One byte is taken every clock cycle unless an end marker waits; each byte
// passes an input register and the per-byte update logic, and the byte with the
// end-of-directory attribute loads the result register. The only back-pressure comes
// from the single result register: an end marker waits while the previous result is
// still held, and other bytes wait only behind it. After an end marker the search
// restarts at offset 0 of a new directory. Query registers sit on the csr port at byte
// addresses 0, 8, 16 and 24 and should be written while no directory is in flight.

module fat_dir_entry_name_match
   import fdm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_dir_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_found,
   output logic [31:0]           rsp_start_cluster,
   output logic [63:0]           rsp_match_name,
   output logic [23:0]           rsp_match_ext,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type   cfg;
   stage_type stage;
   logic      advance;

   fdm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fdm_in_stage u_in (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_dir_byte (req_dir_byte),
      .advance      (advance),
      .stage        (stage)
   );

   fdm_scan u_scan (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .stage             (stage),
      .advance           (advance),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_start_cluster (rsp_start_cluster),
      .rsp_match_name    (rsp_match_name),
      .rsp_match_ext     (rsp_match_ext)
   );

endmodule

// ----- src/fdm_checker.sv -----
`timescale 1ns / 1ps

module fdm_checker
   import fdm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_found,
   input logic [31:0]           rsp_start_cluster,
   input logic [63:0]           rsp_match_name,
   input logic [23:0]           rsp_match_ext,
   input logic                  pready
);

   // input back-pressure only comes from a held result
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // no match reports all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_start_cluster == 32'd0 && rsp_match_name == 64'd0 && rsp_match_ext == 24'd0))
      else $error("miss result carries nonzero fields");

   a_no_result_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind fat_dir_entry_name_match fdm_checker u_chk (.*);
